### rtl/pixd_pkg.sv
// ----------------------------------------------------------------------------
// pixd_pkg
// Shared types and constants for the palette image run-length decoder.
// ----------------------------------------------------------------------------
package pixd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPRESSED  = 2'd1;

    localparam int DEF_MAX_PIXELS = 16 * 1024 * 1024;

    // coding thresholds
    localparam logic [7:0] LIT_BASE = 8'd128;
    localparam logic [7:0] REP_BASE = 8'd192;

    typedef struct packed {
        logic restart;
        logic compressed;
    } cfg_ctrl_t;

    typedef struct packed {
        logic [23:0] start_pixel;
        logic [6:0]  run_length;
        logic [7:0]  color_index;
        logic        transparent;
        logic        image_done;
    } run_t;

endpackage

### rtl/pixd_cfg.sv
// ----------------------------------------------------------------------------
// pixd_cfg
// Configuration registers: pixel count (saturated) and coding mode.
// ----------------------------------------------------------------------------
module pixd_cfg #(
    parameter int MAX_PIXELS = pixd_pkg::DEF_MAX_PIXELS,
    parameter int CNT_W      = $clog2(MAX_PIXELS + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pixd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pixd_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [CNT_W-1:0]               pixel_count,
    output pixd_pkg::cfg_ctrl_t            ctrl
);
    import pixd_pkg::*;

    localparam int WIDE_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;

    logic [CNT_W-1:0]  pixel_count_reg;
    logic [CNT_W-1:0]  pixel_count_next;
    logic              compressed_reg;
    logic              compressed_next;
    logic [WIDE_W-1:0] data_ext;
    logic              wr_count;
    logic              wr_mode;

    assign wr_count = cfg_we && (cfg_index == REG_PIXEL_COUNT);
    assign wr_mode  = cfg_we && (cfg_index == REG_COMPRESSED);
    assign data_ext = WIDE_W'(cfg_data);

    always_comb
    begin
        pixel_count_next = pixel_count_reg;
        compressed_next  = compressed_reg;
        if (wr_count)
        begin
            if (data_ext > WIDE_W'(MAX_PIXELS))
                pixel_count_next = CNT_W'(MAX_PIXELS);
            else
                pixel_count_next = data_ext[CNT_W-1:0];
        end
        if (wr_mode)
            compressed_next = cfg_data[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg <= CNT_W'(1);
            compressed_reg  <= 1'b0;
        end
        else
        begin
            pixel_count_reg <= pixel_count_next;
            compressed_reg  <= compressed_next;
        end
    end

    assign pixel_count     = pixel_count_reg;
    assign ctrl.restart    = wr_count || wr_mode;
    assign ctrl.compressed = compressed_reg;

endmodule

### rtl/pixd_core.sv
// ----------------------------------------------------------------------------
// pixd_core
// Input byte register, decode state and run descriptor generation.
// ----------------------------------------------------------------------------
module pixd_core #(
    parameter int MAX_PIXELS = pixd_pkg::DEF_MAX_PIXELS,
    parameter int CNT_W      = $clog2(MAX_PIXELS + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          stream_byte,
    input  logic [CNT_W-1:0]    pixel_count,
    input  pixd_pkg::cfg_ctrl_t ctrl,
    input  logic                out_free,
    output logic                push,
    output pixd_pkg::run_t      run,
    output logic [CNT_W-1:0]    position,
    output logic [7:0]          literal_left,
    output logic [5:0]          repeat_pending
);
    import pixd_pkg::*;

    localparam int WIDE_W = (CNT_W > 25) ? CNT_W : 25;

    logic              in_valid_reg;
    logic [7:0]        byte_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  pos_next;
    logic [7:0]        lit_reg;
    logic [7:0]        lit_next;
    logic [5:0]        rep_reg;
    logic [5:0]        rep_next;

    logic              active;
    logic              emit;
    logic              adv;
    logic [6:0]        len;
    logic [7:0]        idx;
    logic              transp;
    logic [WIDE_W-1:0] pos_ext;
    logic [WIDE_W-1:0] cnt_ext;
    logic [WIDE_W-1:0] remaining;
    logic [WIDE_W-1:0] len_clip;
    logic [WIDE_W-1:0] pos_sum;

    assign active  = in_valid_reg && (pos_reg < pixel_count);
    assign pos_ext = WIDE_W'(pos_reg);
    assign cnt_ext = WIDE_W'(pixel_count);

    // byte decode
    always_comb
    begin
        emit     = 1'b0;
        len      = 7'd1;
        idx      = byte_reg;
        transp   = 1'b0;
        lit_next = lit_reg;
        rep_next = rep_reg;
        if (ctrl.compressed)
        begin
            if (lit_reg != 8'd0)
            begin
                emit     = 1'b1;
                lit_next = lit_reg - 8'd1;
            end
            else if (byte_reg > LIT_BASE)
            begin
                emit   = 1'b1;
                len    = 7'(byte_reg - LIT_BASE);
                idx    = 8'd0;
                transp = 1'b1;
            end
            else
            begin
                lit_next = byte_reg;
            end
        end
        else
        begin
            if (rep_reg != 6'd0)
            begin
                emit     = 1'b1;
                len      = 7'(rep_reg);
                rep_next = 6'd0;
            end
            else if (byte_reg > REP_BASE)
            begin
                rep_next = 6'(byte_reg - REP_BASE);
            end
            else
            begin
                emit = 1'b1;
            end
        end
    end

    // clip at image end
    always_comb
    begin
        remaining = cnt_ext - pos_ext;
        if (WIDE_W'(len) > remaining)
            len_clip = remaining;
        else
            len_clip = WIDE_W'(len);
        pos_sum  = pos_ext + len_clip;
        pos_next = pos_sum[CNT_W-1:0];
    end

    // a byte with no result never waits on the output side
    assign adv      = in_valid_reg && (!(active && emit) || out_free);
    assign push     = adv && active && emit;
    assign in_stall = in_valid_reg && !adv;

    assign run.start_pixel = pos_ext[23:0];
    assign run.run_length  = len_clip[6:0];
    assign run.color_index = idx;
    assign run.transparent = transp;
    assign run.image_done  = (pos_sum >= cnt_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pos_reg      <= '0;
            lit_reg      <= '0;
            rep_reg      <= '0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (ctrl.restart)
            begin
                pos_reg <= '0;
                lit_reg <= '0;
                rep_reg <= '0;
            end
            else if (adv && active)
            begin
                if (emit)
                    pos_reg <= pos_next;
                lit_reg <= lit_next;
                rep_reg <= rep_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            byte_reg <= stream_byte;
    end

    assign position       = pos_reg;
    assign literal_left   = lit_reg;
    assign repeat_pending = rep_reg;

endmodule

### rtl/pixd_outbuf.sv
// ----------------------------------------------------------------------------
// pixd_outbuf
// Output register for run descriptor beats.
// ----------------------------------------------------------------------------
module pixd_outbuf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pixd_pkg::run_t run_in,
    output logic           out_free,
    output logic           out_valid,
    input  logic           out_stall,
    output pixd_pkg::run_t run_out
);
    import pixd_pkg::*;

    logic out_valid_reg;
    run_t run_reg;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= push;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            run_reg <= run_in;
    end

    assign out_valid = out_valid_reg;
    assign run_out   = run_reg;

endmodule

### rtl/pid_image_rle_decoder.sv
// ----------------------------------------------------------------------------
// pid_image_rle_decoder
// Run-length decoder for palettized image pixel data: one byte in, at most
// one run descriptor out.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | stream_byte
//  out     | out_valid / out_stall| start_pixel, run_length, color_index,
//          |                      | transparent, image_done
//  cfg     | cfg_we               | cfg_index, cfg_data
//
//  One byte per cycle sustained while in_stall is low; a result passes through
//  the input register and is decoded into the output register, from which it
//  can leave.
//  Bytes that only set up a count, and bytes after the image end, give no beat.
//  out_stall holds the output register; in_stall rises only when a byte that
//  produces a run is waiting for that register.
//  Reset: pixel_count 1, plain mode, decode state cleared. A register write
//  also clears the decode state.
// ----------------------------------------------------------------------------
module pid_image_rle_decoder #(
    parameter int MAX_PIXELS = pixd_pkg::DEF_MAX_PIXELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pixd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pixd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      stream_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [23:0]                     start_pixel,
    output logic [6:0]                      run_length,
    output logic [7:0]                      color_index,
    output logic                            transparent,
    output logic                            image_done
);
    import pixd_pkg::*;

    localparam int CNT_W = $clog2(MAX_PIXELS + 1);

    logic [CNT_W-1:0] pixel_count;
    cfg_ctrl_t        ctrl;
    logic             out_free;
    logic             push;
    run_t             run_new;
    run_t             run_out;
    logic [CNT_W-1:0] position;
    logic [7:0]       literal_left;
    logic [5:0]       repeat_pending;

    pixd_cfg #(
        .MAX_PIXELS (MAX_PIXELS),
        .CNT_W      (CNT_W)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_count (pixel_count),
        .ctrl        (ctrl)
    );

    pixd_core #(
        .MAX_PIXELS (MAX_PIXELS),
        .CNT_W      (CNT_W)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .stream_byte    (stream_byte),
        .pixel_count    (pixel_count),
        .ctrl           (ctrl),
        .out_free       (out_free),
        .push           (push),
        .run            (run_new),
        .position       (position),
        .literal_left   (literal_left),
        .repeat_pending (repeat_pending)
    );

    pixd_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .run_in    (run_new),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .run_out   (run_out)
    );

    assign start_pixel = run_out.start_pixel;
    assign run_length  = run_out.run_length;
    assign color_index = run_out.color_index;
    assign transparent = run_out.transparent;
    assign image_done  = run_out.image_done;

    // decode never runs past the image end
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        position <= pixel_count)
        else $error("position beyond pixel_count");

    // a pending repeat and pending literals belong to different modes
    a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !((literal_left != 8'd0) && (repeat_pending != 6'd0)))
        else $error("literal and repeat pending together");

    // a register write restarts decode
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index == REG_PIXEL_COUNT || cfg_index == REG_COMPRESSED)
        |=> (position == '0) && (literal_left == 8'd0) && (repeat_pending == 6'd0))
        else $error("decode state not cleared by register write");

    // a pushed run is visible on the output next cycle
    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_valid)
        else $error("pushed run not presented");

endmodule
